FILE: src/dmct_pkg.sv
// ----------------------------------------------------------------------------
// dmct_pkg: shared types and constants of the cache tag store
// Transaction payloads, operation codes and the controller to datapath
// command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package dmct_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int TAG_W      = 22;
  localparam int OFFSET_W   = 4;
  localparam int OPCODE_W   = 3;
  localparam int ADDR_W     = 32;
  localparam int BIDX_W     = 10;
  localparam int FLAGS_W    = 8;
  localparam int STATUS_O_W = 8;

  // Default values of the top-level parameters.
  localparam int DEF_NUM_BLOCKS    = 1024;
  localparam int DEF_ADDRESS_WIDTH = 32;
  localparam int DEF_STATUS_WIDTH  = 8;

  // Reset value of the block offset register.
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 4'd5;

  // Status word bit positions.
  localparam int ST_VALID_BIT    = 0;
  localparam int ST_MODIFIED_BIT = 1;

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP     = 3'd0,
    OP_FILL       = 3'd1,
    OP_INVALIDATE = 3'd2,
    OP_SET_FLAGS  = 3'd3,
    OP_READ_ENTRY = 3'd4
  } opcode_e;

  // Request transaction.
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
    logic [BIDX_W-1:0]   block_index;
    logic [FLAGS_W-1:0]  flag_bits;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic                  hit;
    logic                  must_writeback;
    logic [STATUS_O_W-1:0] status_bits;
    logic [BIDX_W-1:0]     entry_index;
    logic [TAG_W-1:0]      stored_tag;
    logic [ADDR_W-1:0]     rebuilt_address;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic accept;
    logic exec;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: src/dmct_ram.sv
// ----------------------------------------------------------------------------
// dmct_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/dmct_ctrl.sv
// ----------------------------------------------------------------------------
// dmct_ctrl: sequencing controller of the cache tag store
// Runs the clearing pass after reset, then steps each transaction through
// an accept cycle and an execute cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dmct_ctrl import dmct_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o,
  output logic           busy_o
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/dmct_datapath.sv
// ----------------------------------------------------------------------------
// dmct_datapath: address split, entry store and result logic
// Holds the offset register, the clear counter, the tag and status RAM and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmct_datapath import dmct_pkg::*; #(
  parameter int NUM_BLOCKS    = DEF_NUM_BLOCKS,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int STATUS_WIDTH  = DEF_STATUS_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [OFFSET_W-1:0] cfg_wdata_i,
  input  wire req_t                req_i,
  input  wire ctrl_cmd_t           cmd_i,
  output ctrl_sts_t                sts_o,
  output rsp_t                     rsp_o,
  output logic                     result_valid_o
);

  // RAM address width and the number of index bits taken from an address.
  localparam int AW     = $clog2(NUM_BLOCKS);
  localparam int IBITS  = $clog2(NUM_BLOCKS + 1) - 1;
  localparam int ENTRY_W = STATUS_WIDTH + TAG_W;
  localparam logic [ADDR_W-1:0] AMASK = (ADDRESS_WIDTH >= ADDR_W) ? '1 :
      ADDR_W'((64'd1 << ADDRESS_WIDTH) - 64'd1);
  localparam logic [STATUS_WIDTH-1:0] ST_VALID_V = STATUS_WIDTH'(1);

  logic [OFFSET_W-1:0]     offset_q;
  logic [AW-1:0]           clr_cnt_q;
  logic [OPCODE_W-1:0]     op_q;
  logic [TAG_W-1:0]        tag_q;
  logic [AW-1:0]           idx_q;
  logic [BIDX_W-1:0]       ix_q;
  logic [BIDX_W-1:0]       bidx_q;
  logic [FLAGS_W-1:0]      flags_q;
  logic                    in_range_q;
  rsp_t                    rsp_q, rsp_d;
  logic                    valid_q;

  logic [ADDR_W-1:0]       addr_sh;
  logic [AW-1:0]           rd_addr;
  logic                    addr_op;
  logic [ENTRY_W-1:0]      rdata;
  logic [STATUS_WIDTH-1:0] rd_st;
  logic [TAG_W-1:0]        rd_tag;
  logic [STATUS_WIDTH-1:0] set_st;
  logic                    wr_need;
  logic [ENTRY_W-1:0]      wr_entry;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;

  // Block offset register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RESET;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_cnt_q <= clr_cnt_q + AW'(1);
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AW'(NUM_BLOCKS - 1));

  // Address split and read address selection for an accepted transaction.
  assign addr_sh = (req_i.address & AMASK) >> offset_q;
  assign addr_op = (req_i.opcode == OP_LOOKUP) || (req_i.opcode == OP_FILL) ||
                   (req_i.opcode == OP_INVALIDATE);
  assign rd_addr = addr_op ? AW'(addr_sh[IBITS-1:0]) : AW'(req_i.block_index);

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= req_i.opcode;
      tag_q      <= TAG_W'(addr_sh >> IBITS);
      idx_q      <= rd_addr;
      ix_q       <= addr_op ? BIDX_W'(addr_sh[IBITS-1:0]) : req_i.block_index;
      bidx_q     <= req_i.block_index;
      flags_q    <= req_i.flag_bits;
      in_range_q <= ({7'd0, req_i.block_index} < 17'(NUM_BLOCKS));
    end
  end

  // Entry store: status word above the tag.
  dmct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_BLOCKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign {rd_st, rd_tag} = rdata;
  assign set_st = rd_st | STATUS_WIDTH'(flags_q);

  // Operation execution: result fields and the entry write-back.
  always_comb begin
    rsp_d    = '0;
    wr_need  = 1'b0;
    wr_entry = '0;
    case (opcode_e'(op_q))
      OP_LOOKUP: begin
        rsp_d.hit            = rd_st[ST_VALID_BIT] && (rd_tag == tag_q);
        rsp_d.must_writeback = rd_st[ST_VALID_BIT] && rd_st[ST_MODIFIED_BIT];
        rsp_d.status_bits    = STATUS_O_W'(rd_st);
        rsp_d.entry_index    = ix_q;
        rsp_d.stored_tag     = rd_tag;
      end
      OP_FILL: begin
        wr_need           = 1'b1;
        wr_entry          = {ST_VALID_V, tag_q};
        rsp_d.status_bits = STATUS_O_W'(ST_VALID_V);
        rsp_d.entry_index = ix_q;
        rsp_d.stored_tag  = tag_q;
      end
      OP_INVALIDATE: begin
        wr_need           = 1'b1;
        rsp_d.entry_index = ix_q;
      end
      OP_SET_FLAGS: begin
        rsp_d.entry_index = ix_q;
        if (in_range_q) begin
          wr_need           = 1'b1;
          wr_entry          = {set_st, rd_tag};
          rsp_d.status_bits = STATUS_O_W'(set_st);
          rsp_d.stored_tag  = rd_tag;
        end
      end
      OP_READ_ENTRY: begin
        rsp_d.entry_index = ix_q;
        if (in_range_q) begin
          rsp_d.status_bits     = STATUS_O_W'(rd_st);
          rsp_d.stored_tag      = rd_tag;
          rsp_d.rebuilt_address = ((((ADDR_W'(rd_tag)) << IBITS) |
                                    ADDR_W'(bidx_q)) << offset_q) & AMASK;
        end
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  // Write port shared between the clearing pass and execution.
  assign ram_we    = cmd_i.clr_we || (cmd_i.exec && wr_need);
  assign ram_waddr = cmd_i.clr_we ? clr_cnt_q : idx_q;
  assign ram_wdata = cmd_i.clr_we ? '0 : wr_entry;

  // Result register and strobe.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.exec;
    end
  end

  assign rsp_o          = rsp_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

FILE: src/direct_mapped_cache_tag_store.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_store: tag and status store of a direct-mapped cache
// Lookup, fill, invalidate, set-flags and read-entry operations on one
// tag and status entry per block, selected by address or block number.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                          Handshake
//  --------  -------------------------------  -------------------------------
//  request   start_i, busy_o, req_i           taken when start_i && !busy_o
//  result    result_valid_o, rsp_o            one-cycle strobe, no back-pressure
//  config    cfg_we_i, cfg_wdata_i            written when cfg_we_i is high
//
//  The entry RAM read is registered, so the read-modify-write happens in
//  the cycle after acceptance, and the result strobes in the cycle after
//  that, overlapping the next accept.
//  After reset a clearing pass writes every entry to zero, one per cycle;
//  busy_o stays high until the pass ends. The receiver cannot stall.
//
`default_nettype none

module direct_mapped_cache_tag_store import dmct_pkg::*; #(
  parameter int NUM_BLOCKS    = DEF_NUM_BLOCKS,
  parameter int ADDRESS_WIDTH = DEF_ADDRESS_WIDTH,
  parameter int STATUS_WIDTH  = DEF_STATUS_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [OFFSET_W-1:0] cfg_wdata_i,
  input  wire logic                start_i,
  input  wire req_t                req_i,
  output logic                     busy_o,
  output logic                     result_valid_o,
  output rsp_t                     rsp_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequencing controller.
  dmct_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Datapath with the entry store.
  dmct_datapath #(
    .NUM_BLOCKS    (NUM_BLOCKS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .STATUS_WIDTH  (STATUS_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .rsp_o          (rsp_o),
    .result_valid_o (result_valid_o)
  );

  // An accepted transaction keeps the block busy for one cycle and then
  // produces exactly one result.
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o ##1 result_valid_o)
    else $error("accepted transaction did not produce a result on time");

  // A result strobes for a single cycle.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // Results are presented only once the block is ready for a new request.
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result presented while busy");

  // A hit is only reported for a valid entry.
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && rsp_o.hit) |-> rsp_o.status_bits[ST_VALID_BIT])
    else $error("hit reported for an invalid entry");

endmodule

`default_nettype wire

FILE: dv/tb_direct_mapped_cache_tag_store.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_cache_tag_store: self-checking bench of the cache tag store
// Drives lookup, fill, invalidate, set-flags and read-entry transactions
// under several block offset settings with random idle gaps. A behavioral
// copy of the tag and status store predicts every result, and a checker
// compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_direct_mapped_cache_tag_store;
  import dmct_pkg::*;

  localparam int NUM_BLOCKS  = DEF_NUM_BLOCKS;
  localparam int IDX_W       = 10;
  localparam int CYCLE_LIMIT = 400000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [OFFSET_W-1:0] cfg_wdata_i = '0;
  logic                start_i = 1'b0;
  req_t                req_i = '0;
  logic                busy_o;
  logic                result_valid_o;
  rsp_t                rsp_o;

  // Behavioral copy of the store and of the offset register.
  logic [STATUS_O_W-1:0] status_mem [NUM_BLOCKS];
  logic [TAG_W-1:0]      tag_mem [NUM_BLOCKS];
  logic [OFFSET_W-1:0]   offset_q = OFFSET_RESET;

  // Predicted results in order of acceptance.
  rsp_t tag_results_q [$];

  logic [ADDR_W-1:0] addr_pool [16];
  int burst_left      = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int offsets_used    = 1;

  direct_mapped_cache_tag_store u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .req_i          (req_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d results outstanding", $time,
               tag_results_q.size());
      $display("[direct_mapped_cache_tag_store] ERROR");
      $finish;
    end
  end

  // Address split under the current offset setting.
  function automatic logic [IDX_W-1:0] addr_to_index(logic [ADDR_W-1:0] addr);
    logic [63:0] shifted;
    shifted = {32'b0, addr} >> offset_q;
    return shifted[IDX_W-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] addr_to_tag(logic [ADDR_W-1:0] addr);
    logic [63:0] shifted;
    shifted = ({32'b0, addr} >> offset_q) >> IDX_W;
    return shifted[TAG_W-1:0];
  endfunction

  // Applies one transaction to the store copy and returns its result.
  function automatic rsp_t apply_tag_op(req_t r);
    rsp_t             o;
    logic [IDX_W-1:0] ix;
    logic [TAG_W-1:0] tg;
    logic [63:0]      wide;
    o = '0;
    case (r.opcode)
      OP_LOOKUP, OP_FILL, OP_INVALIDATE: begin
        ix = addr_to_index(r.address);
        tg = addr_to_tag(r.address);
        if (r.opcode == OP_FILL) begin
          status_mem[ix] = '0;
          status_mem[ix][ST_VALID_BIT] = 1'b1;
          tag_mem[ix] = tg;
        end else if (r.opcode == OP_INVALIDATE) begin
          status_mem[ix] = '0;
          tag_mem[ix] = '0;
        end else begin
          o.hit = status_mem[ix][ST_VALID_BIT] && (tag_mem[ix] == tg);
          o.must_writeback = status_mem[ix][ST_VALID_BIT] &&
                             status_mem[ix][ST_MODIFIED_BIT];
        end
        o.entry_index = ix;
        o.status_bits = status_mem[ix];
        o.stored_tag  = tag_mem[ix];
      end
      OP_SET_FLAGS, OP_READ_ENTRY: begin
        o.entry_index = r.block_index;
        if (int'(r.block_index) < NUM_BLOCKS) begin
          if (r.opcode == OP_SET_FLAGS)
            status_mem[r.block_index] = status_mem[r.block_index] | r.flag_bits;
          o.status_bits = status_mem[r.block_index];
          o.stored_tag  = tag_mem[r.block_index];
          if (r.opcode == OP_READ_ENTRY) begin
            wide = ((64'(tag_mem[r.block_index]) << IDX_W) | 64'(r.block_index))
                   << offset_q;
            o.rebuilt_address = wide[ADDR_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Idle gap after a transaction: mostly none, some short, a few long,
  // and now and then a burst with no gaps at all.
  function automatic int next_gap();
    int p;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    p = $urandom_range(0, 99);
    if (p < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic req_t make_req(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr,
                                    logic [BIDX_W-1:0] bidx, logic [FLAGS_W-1:0] flags);
    req_t r;
    r.opcode      = op;
    r.address     = addr;
    r.block_index = bidx;
    r.flag_bits   = flags;
    return r;
  endfunction

  // Sends one transaction and records its predicted result on acceptance.
  // start_i stays high when no gap follows, so back-to-back items keep it up.
  task automatic send_req(input req_t r);
    int gap;
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    tag_results_q.push_back(apply_tag_op(r));
    items_sent++;
    gap = next_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Stops issuing and waits until every predicted result has arrived.
  task automatic wait_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (tag_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the offset register while the block is idle.
  task automatic write_offset(input logic [OFFSET_W-1:0] value);
    wait_idle();
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    offset_q = value;
    offsets_used++;
  endtask

  // Compares one field and reports a mismatch.
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Result checker: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    rsp_t exp_r;
    if (rst_ni && result_valid_o) begin
      if (tag_results_q.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, rsp_o);
        mismatches++;
      end else begin
        exp_r = tag_results_q.pop_front();
        results_checked++;
        check_field("hit", 32'(exp_r.hit), 32'(rsp_o.hit));
        check_field("must_writeback", 32'(exp_r.must_writeback),
                    32'(rsp_o.must_writeback));
        check_field("status_bits", 32'(exp_r.status_bits), 32'(rsp_o.status_bits));
        check_field("entry_index", 32'(exp_r.entry_index), 32'(rsp_o.entry_index));
        check_field("stored_tag", 32'(exp_r.stored_tag), 32'(rsp_o.stored_tag));
        check_field("rebuilt_address", exp_r.rebuilt_address, rsp_o.rebuilt_address);
      end
    end
  end

  // Fresh address pool: the upper half aliases the lower half on the index
  // with a different tag, so hits, misses and conflicts all occur.
  task automatic refresh_addr_pool();
    logic [63:0] tag_flip;
    for (int i = 0; i < 8; i++) begin
      addr_pool[i] = $urandom;
      tag_flip = {32'b0, $urandom} << (offset_q + IDX_W);
      addr_pool[i+8] = addr_pool[i] ^ tag_flip[ADDR_W-1:0];
    end
  endtask

  // Directed checks of every operation and the corner cases.
  task automatic test_directed_ops();
    logic [ADDR_W-1:0] a_hi;
    logic [IDX_W-1:0]  ix_hi;
    logic [ADDR_W-1:0] a_ix3;
    a_hi  = 32'hFFFF_FFFF;
    ix_hi = addr_to_index(a_hi);
    a_ix3 = 32'(3) << offset_q;
    // Lookup and read on the cleared store.
    send_req(make_req(OP_LOOKUP, 32'h0, '0, '0));
    send_req(make_req(OP_READ_ENTRY, '0, 10'd0, '0));
    // Fill, hit, and a conflicting tag on the same index.
    send_req(make_req(OP_FILL, a_hi, '0, '0));
    send_req(make_req(OP_LOOKUP, a_hi, '0, '0));
    send_req(make_req(OP_LOOKUP, a_hi ^ 32'h8000_0000, '0, '0));
    // Every status bit set, so the lookup asks for a write-back.
    send_req(make_req(OP_SET_FLAGS, '0, ix_hi, 8'hFF));
    send_req(make_req(OP_LOOKUP, a_hi, 10'h3FF, 8'hFF));
    send_req(make_req(OP_READ_ENTRY, a_hi, ix_hi, '0));
    // A refill leaves only the valid bit.
    send_req(make_req(OP_FILL, a_hi, '0, '0));
    send_req(make_req(OP_LOOKUP, a_hi, '0, '0));
    // Invalidate clears both status and tag.
    send_req(make_req(OP_INVALIDATE, a_hi, '0, '0));
    send_req(make_req(OP_READ_ENTRY, '0, ix_hi, '0));
    // Modified but not valid: no hit and no write-back.
    send_req(make_req(OP_SET_FLAGS, '0, 10'd3, 8'h02));
    send_req(make_req(OP_LOOKUP, a_ix3, '0, '0));
    // Top block number and an empty flag mask.
    send_req(make_req(OP_SET_FLAGS, '0, 10'h3FF, 8'h00));
    send_req(make_req(OP_READ_ENTRY, '0, 10'h3FF, '0));
    // User flag bits on a filled entry.
    send_req(make_req(OP_FILL, 32'h0, '0, '0));
    send_req(make_req(OP_SET_FLAGS, '0, 10'd0, 8'h80));
    send_req(make_req(OP_READ_ENTRY, '0, 10'd0, '0));
    // Unused opcodes change nothing and return zeros.
    send_req(make_req(3'd5, a_hi, 10'h3FF, 8'hFF));
    send_req(make_req(3'd6, $urandom, 10'($urandom), 8'($urandom)));
    send_req(make_req(3'd7, 32'h0, 10'd0, 8'h00));
    send_req(make_req(OP_READ_ENTRY, '0, 10'd0, '0));
    send_req(make_req(OP_FILL, a_hi, '0, '0));
    send_req(make_req(OP_INVALIDATE, 32'h0, '0, '0));
  endtask

  // Random mix of operations, biased toward addresses already in use.
  task automatic test_random_traffic(input int count);
    int                  p;
    logic [OPCODE_W-1:0] op;
    logic [ADDR_W-1:0]   addr;
    logic [BIDX_W-1:0]   bidx;
    refresh_addr_pool();
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      if (p < 35)      op = OP_LOOKUP;
      else if (p < 60) op = OP_FILL;
      else if (p < 70) op = OP_INVALIDATE;
      else if (p < 82) op = OP_SET_FLAGS;
      else if (p < 95) op = OP_READ_ENTRY;
      else             op = OPCODE_W'($urandom_range(5, 7));
      addr = ($urandom_range(0, 1) == 1) ? addr_pool[$urandom_range(0, 15)] : $urandom;
      bidx = ($urandom_range(0, 9) < 6) ? addr_to_index(addr_pool[$urandom_range(0, 15)])
                                        : 10'($urandom);
      send_req(make_req(op, addr, bidx, 8'($urandom)));
      if ($urandom_range(0, 63) == 0) refresh_addr_pool();
    end
  endtask

  // Offset extremes: none, the largest nominal, and two values above it.
  task automatic test_offset_extremes();
    logic [OFFSET_W-1:0] sweep [4];
    sweep = '{4'd0, 4'd12, 4'd15, 4'd13};
    foreach (sweep[i]) begin
      write_offset(sweep[i]);
      test_random_traffic(175);
    end
  endtask

  // Short phases under random offset settings.
  task automatic test_random_offsets();
    for (int i = 0; i < 5; i++) begin
      write_offset(OFFSET_W'($urandom_range(0, 15)));
      test_random_traffic(25);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      status_mem[i] = '0;
      tag_mem[i]    = '0;
    end
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_ops();
    test_random_traffic(200);
    test_offset_extremes();
    test_random_offsets();

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d transactions, checked %0d results under %0d offset settings.",
             items_sent, results_checked, offsets_used);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0 && tag_results_q.size() == 0) begin
      $display("[direct_mapped_cache_tag_store] OK");
    end else begin
      $display("[direct_mapped_cache_tag_store] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
src/dmct_pkg.sv
src/dmct_ram.sv
src/dmct_ctrl.sv
src/dmct_datapath.sv
src/direct_mapped_cache_tag_store.sv
dv/tb_direct_mapped_cache_tag_store.sv
